// File: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/sdh_pkg.sv
package sdh_pkg;

   localparam int BLOCK_BYTES = 512;

   localparam logic [2:0] A_INIT  = 3'd0;
   localparam logic [2:0] A_READ  = 3'd1;
   localparam logic [2:0] A_WRITE = 3'd2;
   localparam logic [2:0] A_BYTE  = 3'd3;
   localparam logic [2:0] A_WDATA = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTREADY = 3'd1;
   localparam logic [2:0] ST_REJECT   = 3'd2;
   localparam logic [2:0] ST_NORESP   = 3'd3;
   localparam logic [2:0] ST_INITFAIL = 3'd4;

   localparam logic [2:0] K_NONE  = 3'd0;
   localparam logic [2:0] K_MMC   = 3'd1;
   localparam logic [2:0] K_V1    = 3'd2;
   localparam logic [2:0] K_V2    = 3'd3;
   localparam logic [2:0] K_V2HC  = 3'd4;
   localparam logic [2:0] K_ERROR = 3'd5;

   localparam logic [4:0] S_NONE   = 5'd0;
   localparam logic [4:0] S_RDY    = 5'd1;
   localparam logic [4:0] S_DESEL  = 5'd2;
   localparam logic [4:0] S_FRAME  = 5'd3;
   localparam logic [4:0] S_STUFF  = 5'd4;
   localparam logic [4:0] S_RESP   = 5'd5;
   localparam logic [4:0] S_RAW    = 5'd6;
   localparam logic [4:0] S_TOKEN  = 5'd7;
   localparam logic [4:0] S_DIN    = 5'd8;
   localparam logic [4:0] S_CRCIN  = 5'd9;
   localparam logic [4:0] S_BRDY   = 5'd10;
   localparam logic [4:0] S_TOK    = 5'd11;
   localparam logic [4:0] S_NEED   = 5'd12;
   localparam logic [4:0] S_DOUT   = 5'd13;
   localparam logic [4:0] S_CRCOUT = 5'd14;
   localparam logic [4:0] S_DRESP  = 5'd15;
   localparam logic [4:0] S_END    = 5'd16;

   localparam logic [4:0] P_IDLE   = 5'd0;
   localparam logic [4:0] I_CLK    = 5'd1;
   localparam logic [4:0] I_CMD0   = 5'd2;
   localparam logic [4:0] I_CMD8   = 5'd3;
   localparam logic [4:0] I_R7     = 5'd4;
   localparam logic [4:0] I_V2_55  = 5'd5;
   localparam logic [4:0] I_V2_41  = 5'd6;
   localparam logic [4:0] I_CMD58  = 5'd7;
   localparam logic [4:0] I_OCR    = 5'd8;
   localparam logic [4:0] I_A55    = 5'd9;
   localparam logic [4:0] I_A41    = 5'd10;
   localparam logic [4:0] I_V1_55  = 5'd11;
   localparam logic [4:0] I_V1_41  = 5'd12;
   localparam logic [4:0] I_MMC1   = 5'd13;
   localparam logic [4:0] I_CMD16  = 5'd14;
   localparam logic [4:0] R_SINGLE = 5'd15;
   localparam logic [4:0] R_SBLK   = 5'd16;
   localparam logic [4:0] R_MCMD   = 5'd17;
   localparam logic [4:0] R_MBLK   = 5'd18;
   localparam logic [4:0] R_STOP   = 5'd19;
   localparam logic [4:0] W_SCMD   = 5'd20;
   localparam logic [4:0] W_SBLK   = 5'd21;
   localparam logic [4:0] W_55     = 5'd22;
   localparam logic [4:0] W_23     = 5'd23;
   localparam logic [4:0] W_MCMD   = 5'd24;
   localparam logic [4:0] W_MBLK   = 5'd25;
   localparam logic [4:0] W_STOP   = 5'd26;
   localparam logic [4:0] P_FIN    = 5'd27;

   localparam logic [2:0] REG_READY_POLL = 3'd0;
   localparam logic [2:0] REG_TOKEN_POLL = 3'd1;
   localparam logic [2:0] REG_INIT_LOOP  = 3'd2;
   localparam logic [2:0] REG_RESET_TRY  = 3'd3;
   localparam logic [2:0] REG_RESP_POLL  = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sector_number;
      logic [7:0]  sector_count;
      logic [7:0]  data_byte;
   } entry_type;

   typedef struct packed {
      logic [23:0] ready_poll_limit;
      logic [15:0] token_poll_limit;
      logic [15:0] init_loop_limit;
      logic [7:0]  reset_retry_limit;
      logic [7:0]  response_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       exchange_request;
      logic       chip_select_level;
      logic       slow_clock;
      logic [7:0] read_data;
      logic       read_valid;
      logic       need_write_data;
      logic       done_res;
      logic [2:0] status;
      logic [2:0] card_kind;
   } rsp_type;

endpackage

// File: rtl/sdh_front.sv
module sdh_front import sdh_pkg::*; (
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [55:0] req_payload,
   output logic        push,
   output entry_type   entry
);

   // unknown action codes never enter the queue
   assign push = req_valid && req_ready && (req_action <= A_WDATA);

   always_comb begin
      entry.action        = req_action;
      entry.sector_number = req_payload[31:0];
      entry.sector_count  = req_payload[39:32];
      entry.data_byte     = (req_action == A_WDATA) ? req_payload[55:48] : req_payload[47:40];
   end

endmodule

// File: rtl/sdh_queue.sv
module sdh_queue import sdh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/sdh_back.sv
module sdh_back import sdh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp
);

   logic [4:0]  phase_ff, phase_in;
   logic [4:0]  stage_ff, stage_in;
   logic [2:0]  card_ff, card_in;
   logic [47:0] frame_ff, frame_in;
   logic [2:0]  fidx_ff, fidx_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [23:0] poll_ff, poll_in;
   logic [15:0] loop_ff, loop_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  lresp_ff, lresp_in;
   logic        speed_ff, speed_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [3:0]  rawtot_ff, rawtot_in;
   logic [7:0]  tok_ff, tok_in;
   logic [2:0]  blk_ff, blk_in;
   logic [2:0]  kept_ff, kept_in;
   logic [2:0]  fin_ff, fin_in;
   logic        cs_ff, cs_in;
   logic        held_ff, held_in;
   logic        nrdy_ff, nrdy_in;
   logic        initf_ff, initf_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic        out_free, go, gen;
   logic        do_res, do_cmd, do_raw, do_recv, do_send, do_fin, do_iend, xff;
   logic [5:0]  c_idx;
   logic [31:0] c_arg;
   logic [7:0]  c_crc, send_tok;
   logic [2:0]  f_st;
   logic [3:0]  raw_n;
   logic [7:0]  b, r, left_dec;
   logic [23:0] poll_inc;
   logic [9:0]  bcnt_inc;
   logic [2:0]  fidx_inc;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign go        = head_valid && out_free;
   assign pop       = go;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      phase_in = phase_ff; stage_in = stage_ff; card_in = card_ff; frame_in = frame_ff;
      fidx_in = fidx_ff; bcnt_in = bcnt_ff; poll_in = poll_ff; loop_in = loop_ff;
      addr_in = addr_ff; left_in = left_ff; lresp_in = lresp_ff; speed_in = speed_ff;
      cidx_in = cidx_ff; rawtot_in = rawtot_ff; tok_in = tok_ff; blk_in = blk_ff;
      kept_in = kept_ff; fin_in = fin_ff; cs_in = cs_ff; held_in = held_ff;
      nrdy_in = nrdy_ff; initf_in = initf_ff;
      gen = 1'b0; do_res = 1'b0; do_cmd = 1'b0; do_raw = 1'b0; do_recv = 1'b0;
      do_send = 1'b0; do_fin = 1'b0; do_iend = 1'b0; xff = 1'b0;
      c_idx = 6'd0; c_arg = 32'd0; c_crc = 8'h01; send_tok = 8'h00; f_st = ST_OK;
      raw_n = 4'd0;
      out_in = '0;
      b = head_entry.data_byte;
      poll_inc = poll_ff + 24'd1;
      bcnt_inc = bcnt_ff + 10'd1;
      fidx_inc = fidx_ff + 3'd1;
      left_dec = left_ff - 8'd1;

      if (go) begin
         case (head_entry.action)
            A_INIT: begin
               if (phase_ff == P_IDLE) begin
                  phase_in = I_CLK; speed_in = 1'b1; cs_in = 1'b1; card_in = K_NONE;
                  initf_in = 1'b1; do_raw = 1'b1; raw_n = 4'd10;
               end
            end
            A_READ, A_WRITE: begin
               if (phase_ff == P_IDLE) begin
                  if (head_entry.sector_count == 8'd0) begin
                     gen = 1'b1; out_in.done_res = 1'b1;
                  end else begin
                     addr_in = (card_ff == K_V2HC) ? head_entry.sector_number
                                                   : {head_entry.sector_number[22:0], 9'd0};
                     left_in = head_entry.sector_count;
                     do_cmd  = 1'b1;
                     c_arg   = addr_in;
                     if (head_entry.action == A_READ) begin
                        if (head_entry.sector_count == 8'd1) begin
                           phase_in = R_SINGLE; c_idx = 6'd17;
                        end else begin
                           phase_in = R_MCMD; c_idx = 6'd18;
                        end
                     end else if (head_entry.sector_count == 8'd1) begin
                        phase_in = W_SCMD; c_idx = 6'd24;
                     end else if (card_ff != K_MMC) begin
                        phase_in = W_55; c_idx = 6'd55; c_arg = 32'd0;
                     end else begin
                        phase_in = W_MCMD; c_idx = 6'd25;
                     end
                  end
               end
            end
            A_BYTE: begin
               if (!(stage_ff inside {S_NONE, S_NEED})) begin
                  case (stage_ff)
                     S_RDY: begin
                        if (b == 8'hFF) begin
                           fidx_in = 3'd0; stage_in = S_FRAME; gen = 1'b1;
                           out_in.exchange_request = 1'b1; out_in.send_byte = frame_ff[47:40];
                        end else begin
                           poll_in = poll_inc;
                           if (poll_inc >= cfg.ready_poll_limit) begin
                              cs_in = 1'b1; stage_in = S_DESEL;
                           end
                           xff = 1'b1;
                        end
                     end
                     S_DESEL: begin
                        nrdy_in = 1'b1; lresp_in = 8'hFF; stage_in = S_NONE; do_res = 1'b1;
                     end
                     S_FRAME: begin
                        fidx_in = fidx_inc;
                        if (fidx_inc < 3'd6) begin
                           gen = 1'b1; out_in.exchange_request = 1'b1;
                           case (fidx_inc)
                              3'd1:    out_in.send_byte = frame_ff[39:32];
                              3'd2:    out_in.send_byte = frame_ff[31:24];
                              3'd3:    out_in.send_byte = frame_ff[23:16];
                              3'd4:    out_in.send_byte = frame_ff[15:8];
                              default: out_in.send_byte = frame_ff[7:0];
                           endcase
                        end else if (cidx_ff == 6'd12) begin
                           stage_in = S_STUFF; xff = 1'b1;
                        end else begin
                           stage_in = S_RESP; poll_in = 24'd0; xff = 1'b1;
                        end
                     end
                     S_STUFF: begin
                        stage_in = S_RESP; poll_in = 24'd0; xff = 1'b1;
                     end
                     S_RESP: begin
                        if (b[7] && (poll_ff < {16'd0, cfg.response_poll_limit})) begin
                           poll_in = poll_inc; xff = 1'b1;
                        end else begin
                           lresp_in = b; nrdy_in = 1'b0; stage_in = S_NONE; do_res = 1'b1;
                        end
                     end
                     S_RAW: begin
                        if (phase_ff == I_R7) begin
                           if (bcnt_ff == 10'd2) held_in = (b == 8'h01);
                           if (bcnt_ff == 10'd3) held_in = held_ff && (b == 8'hAA);
                        end else if (bcnt_ff == 10'd0) begin
                           held_in = b[6];
                        end
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc >= {6'd0, rawtot_ff}) begin
                           stage_in = S_NONE; do_res = 1'b1;
                        end else begin
                           xff = 1'b1;
                        end
                     end
                     S_TOKEN: begin
                        if (b == 8'hFE) begin
                           bcnt_in = 10'd0; stage_in = S_DIN; xff = 1'b1;
                        end else begin
                           poll_in = poll_inc;
                           if (poll_inc >= {8'd0, cfg.token_poll_limit}) begin
                              blk_in = ST_NORESP; stage_in = S_NONE; do_res = 1'b1;
                           end else begin
                              xff = 1'b1;
                           end
                        end
                     end
                     S_DIN: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc >= 10'(BLOCK_BYTES)) begin
                           stage_in = S_CRCIN; bcnt_in = 10'd0;
                        end
                        xff = 1'b1; out_in.read_data = b; out_in.read_valid = 1'b1;
                     end
                     S_CRCIN: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc < 10'd2) begin
                           xff = 1'b1;
                        end else begin
                           blk_in = ST_OK; stage_in = S_NONE; do_res = 1'b1;
                        end
                     end
                     S_BRDY: begin
                        if (b == 8'hFF) begin
                           stage_in = S_TOK; gen = 1'b1;
                           out_in.exchange_request = 1'b1; out_in.send_byte = tok_ff;
                        end else begin
                           poll_in = poll_inc;
                           if (poll_inc >= cfg.ready_poll_limit) begin
                              blk_in = ST_NOTREADY; stage_in = S_NONE; do_res = 1'b1;
                           end else begin
                              xff = 1'b1;
                           end
                        end
                     end
                     S_TOK: begin
                        if (tok_ff == 8'hFD) begin
                           blk_in = ST_OK; stage_in = S_NONE; do_res = 1'b1;
                        end else begin
                           bcnt_in = 10'd0; stage_in = S_NEED; gen = 1'b1;
                           out_in.need_write_data = 1'b1;
                        end
                     end
                     S_DOUT: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc < 10'(BLOCK_BYTES)) begin
                           stage_in = S_NEED; gen = 1'b1; out_in.need_write_data = 1'b1;
                        end else begin
                           stage_in = S_CRCOUT; bcnt_in = 10'd0; xff = 1'b1;
                        end
                     end
                     S_CRCOUT: begin
                        bcnt_in = bcnt_inc;
                        if (bcnt_inc >= 10'd2) stage_in = S_DRESP;
                        xff = 1'b1;
                     end
                     S_DRESP: begin
                        blk_in = (b[4:0] == 5'h05) ? ST_OK : ST_REJECT;
                        stage_in = S_NONE; do_res = 1'b1;
                     end
                     S_END: begin
                        if (initf_ff) speed_in = 1'b0;
                        initf_in = 1'b0; stage_in = S_NONE; phase_in = P_IDLE; gen = 1'b1;
                        out_in.done_res = 1'b1; out_in.status = fin_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            A_WDATA: begin
               if (stage_ff == S_NEED) begin
                  stage_in = S_DOUT; gen = 1'b1;
                  out_in.exchange_request = 1'b1; out_in.send_byte = b;
               end
            end
            default: begin
            end
         endcase
      end

      r = lresp_in;
      if (do_res) begin
         case (phase_ff)
            I_CLK: begin
               phase_in = I_CMD0; loop_in = {8'd0, cfg.reset_retry_limit};
               do_cmd = 1'b1; c_idx = 6'd0; c_crc = 8'h95;
            end
            I_CMD0: begin
               if (r == 8'h01) begin
                  phase_in = I_CMD8; do_cmd = 1'b1; c_idx = 6'd8;
                  c_arg = 32'h1AA; c_crc = 8'h87;
               end else if (loop_ff == 16'd0) begin
                  do_iend = 1'b1;
               end else begin
                  loop_in = loop_ff - 16'd1; do_cmd = 1'b1; c_idx = 6'd0; c_crc = 8'h95;
               end
            end
            I_CMD8: begin
               if (r == 8'h01) begin
                  phase_in = I_R7; do_raw = 1'b1; raw_n = 4'd4;
               end else begin
                  phase_in = I_A55; do_cmd = 1'b1; c_idx = 6'd55;
               end
            end
            I_R7: begin
               if (held_in) begin
                  phase_in = I_V2_55; loop_in = cfg.init_loop_limit;
                  do_cmd = 1'b1; c_idx = 6'd55;
               end else begin
                  do_iend = 1'b1;
               end
            end
            I_V2_55: begin
               phase_in = I_V2_41; do_cmd = 1'b1; c_idx = 6'd41; c_arg = 32'h40000000;
            end
            I_V2_41: begin
               if (r == 8'h00) begin
                  phase_in = I_CMD58; do_cmd = 1'b1; c_idx = 6'd58;
               end else if (loop_ff == 16'd0) begin
                  do_iend = 1'b1;
               end else begin
                  loop_in = loop_ff - 16'd1; phase_in = I_V2_55;
                  do_cmd = 1'b1; c_idx = 6'd55;
               end
            end
            I_CMD58: begin
               if (r == 8'h00) begin
                  phase_in = I_OCR; do_raw = 1'b1; raw_n = 4'd4;
               end else begin
                  do_iend = 1'b1;
               end
            end
            I_OCR: begin
               card_in = held_in ? K_V2HC : K_V2; do_iend = 1'b1;
            end
            I_A55: begin
               phase_in = I_A41; do_cmd = 1'b1; c_idx = 6'd41;
            end
            I_A41: begin
               loop_in = cfg.init_loop_limit; do_cmd = 1'b1;
               if (r <= 8'h01) begin
                  card_in = K_V1; phase_in = I_V1_55; c_idx = 6'd55;
               end else begin
                  card_in = K_MMC; phase_in = I_MMC1; c_idx = 6'd1;
               end
            end
            I_V1_55: begin
               phase_in = I_V1_41; do_cmd = 1'b1; c_idx = 6'd41;
            end
            I_V1_41, I_MMC1: begin
               if (r == 8'h00) begin
                  phase_in = I_CMD16; do_cmd = 1'b1; c_idx = 6'd16;
                  c_arg = 32'(BLOCK_BYTES);
               end else if (loop_ff == 16'd0) begin
                  card_in = K_ERROR; do_iend = 1'b1;
               end else if (phase_ff == I_MMC1) begin
                  loop_in = loop_ff - 16'd1; do_cmd = 1'b1; c_idx = 6'd1;
               end else begin
                  loop_in = loop_ff - 16'd1; phase_in = I_V1_55;
                  do_cmd = 1'b1; c_idx = 6'd55;
               end
            end
            I_CMD16: begin
               if (r != 8'h00) card_in = K_ERROR;
               do_iend = 1'b1;
            end
            R_SINGLE, W_SCMD, W_MCMD: begin
               if (r != 8'h00) begin
                  do_fin = 1'b1; f_st = nrdy_in ? ST_NOTREADY : ST_NORESP;
               end else if (phase_ff == R_SINGLE) begin
                  phase_in = R_SBLK; do_recv = 1'b1;
               end else if (phase_ff == W_SCMD) begin
                  phase_in = W_SBLK; do_send = 1'b1; send_tok = 8'hFE;
               end else begin
                  phase_in = W_MBLK; do_send = 1'b1; send_tok = 8'hFC;
               end
            end
            R_SBLK, W_SBLK: begin
               do_fin = 1'b1; f_st = blk_in;
            end
            R_MCMD: begin
               phase_in = R_MBLK; do_recv = 1'b1;
            end
            R_MBLK: begin
               left_in = left_dec;
               if (left_dec != 8'd0 && blk_in == ST_OK) begin
                  do_recv = 1'b1;
               end else begin
                  kept_in = blk_in; phase_in = R_STOP; do_cmd = 1'b1; c_idx = 6'd12;
               end
            end
            R_STOP: begin
               do_fin = 1'b1; f_st = kept_ff;
            end
            W_55: begin
               phase_in = W_23; do_cmd = 1'b1; c_idx = 6'd23; c_arg = {24'd0, left_ff};
            end
            W_23: begin
               phase_in = W_MCMD; do_cmd = 1'b1; c_idx = 6'd25; c_arg = addr_ff;
            end
            W_MBLK: begin
               left_in = left_dec; do_send = 1'b1;
               if (left_dec != 8'd0 && blk_in == ST_OK) begin
                  send_tok = 8'hFC;
               end else begin
                  kept_in = blk_in; phase_in = W_STOP; send_tok = 8'hFD;
               end
            end
            W_STOP: begin
               do_fin = 1'b1; f_st = (kept_ff != ST_OK) ? kept_ff : blk_in;
            end
            default: begin
               stage_in = S_NONE; phase_in = P_IDLE;
            end
         endcase
      end

      if (do_iend) begin
         do_fin = 1'b1;
         f_st = (card_in >= K_MMC && card_in <= K_V2HC) ? ST_OK : ST_INITFAIL;
      end
      if (do_cmd) begin
         frame_in = {2'b01, c_idx, c_arg, c_crc};
         cidx_in = c_idx; cs_in = 1'b0; poll_in = 24'd0; stage_in = S_RDY; xff = 1'b1;
      end
      if (do_raw) begin
         rawtot_in = raw_n; bcnt_in = 10'd0; stage_in = S_RAW; held_in = 1'b0; xff = 1'b1;
      end
      if (do_recv) begin
         poll_in = 24'd0; stage_in = S_TOKEN; xff = 1'b1;
      end
      if (do_send) begin
         tok_in = send_tok; poll_in = 24'd0; stage_in = S_BRDY; xff = 1'b1;
      end
      if (do_fin) begin
         fin_in = f_st; cs_in = 1'b1; stage_in = S_END; phase_in = P_FIN; xff = 1'b1;
      end
      if (xff) begin
         gen = 1'b1; out_in.exchange_request = 1'b1; out_in.send_byte = 8'hFF;
      end

      out_in.chip_select_level = cs_in;
      out_in.slow_clock        = speed_in;
      out_in.card_kind         = card_in;

      out_valid_in = out_free ? (go && gen) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; stage_ff <= S_NONE; card_ff <= K_NONE; frame_ff <= '0;
         fidx_ff <= '0; bcnt_ff <= '0; poll_ff <= '0; loop_ff <= '0; addr_ff <= '0;
         left_ff <= '0; lresp_ff <= '0; speed_ff <= 1'b1; cidx_ff <= '0;
         rawtot_ff <= '0; tok_ff <= '0; blk_ff <= ST_OK; kept_ff <= ST_OK;
         fin_ff <= ST_OK; cs_ff <= 1'b1; held_ff <= 1'b0; nrdy_ff <= 1'b0;
         initf_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; stage_ff <= stage_in; card_ff <= card_in;
         frame_ff <= frame_in; fidx_ff <= fidx_in; bcnt_ff <= bcnt_in;
         poll_ff <= poll_in; loop_ff <= loop_in; addr_ff <= addr_in;
         left_ff <= left_in; lresp_ff <= lresp_in; speed_ff <= speed_in;
         cidx_ff <= cidx_in; rawtot_ff <= rawtot_in; tok_ff <= tok_in;
         blk_ff <= blk_in; kept_ff <= kept_in; fin_ff <= fin_in; cs_ff <= cs_in;
         held_ff <= held_in; nrdy_ff <= nrdy_in; initf_ff <= initf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && go) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: rtl/sd_spi_card_host_sequencer.sv
// SPI-mode SD card host sequencer.
// req channel: tuser carries the action (init, read, write, card byte, write
// data byte); tdata carries sector number, sector count, card byte and write
// data. Every item that causes a result yields exactly one rsp item: an SPI
// exchange request (send_byte), a received sector byte, a request for the
// next write data byte, or the end of a request (tlast) with status and
// card kind. Items that mean nothing in the current state are taken and
// dropped without a result.
// An accepted item passes through a queue slot, then the output register, before
// its result is presented.
// Throughput: one item per cycle while the output register is free; the
// sequencer updates its state once per item. A two-entry queue parts the
// request side from the sequencer, and the output register holds a result
// while rsp_tready is low; the queue keeps taking items until it is full.
// Reset: idle, no card known, chip select high, slow clock, limits at their
// reset values. The csr port is an apb-style register file at 4*index.
`include "assert_macros.svh"

module sd_spi_card_host_sequencer import sdh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sector_number[31:0], sector_count[39:32], card_byte[47:40], write_data[55:48]
   input  logic [55:0] req_tdata,
   // action[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // send_byte[7:0], chip_select_level[8], slow_clock[9], read_data[17:10],
   // status[20:18], card_kind[23:21]
   output logic [23:0] rsp_tdata,
   // exchange_request[0], read_valid[1], need_write_data[2]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type   cfg_ff, cfg_in;
   logic      push, full, pop, head_valid;
   entry_type push_entry, head_entry;
   rsp_type   rsp;
   logic      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_READY_POLL: cfg_in.ready_poll_limit    = csr_pwdata[23:0];
            REG_TOKEN_POLL: cfg_in.token_poll_limit    = csr_pwdata[15:0];
            REG_INIT_LOOP:  cfg_in.init_loop_limit     = csr_pwdata[15:0];
            REG_RESET_TRY:  cfg_in.reset_retry_limit   = csr_pwdata[7:0];
            REG_RESP_POLL:  cfg_in.response_poll_limit = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_READY_POLL: csr_prdata = {8'd0, cfg_ff.ready_poll_limit};
         REG_TOKEN_POLL: csr_prdata = {16'd0, cfg_ff.token_poll_limit};
         REG_INIT_LOOP:  csr_prdata = {16'd0, cfg_ff.init_loop_limit};
         REG_RESET_TRY:  csr_prdata = {24'd0, cfg_ff.reset_retry_limit};
         REG_RESP_POLL:  csr_prdata = {24'd0, cfg_ff.response_poll_limit};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_poll_limit    <= 24'hFFFFFF;
         cfg_ff.token_poll_limit    <= 16'd65535;
         cfg_ff.init_loop_limit     <= 16'd65534;
         cfg_ff.reset_retry_limit   <= 8'd20;
         cfg_ff.response_poll_limit <= 8'd31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;

   sdh_front u_front (
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tuser),
      .req_payload (req_tdata),
      .push        (push),
      .entry       (push_entry)
   );

   sdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sdh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {rsp.card_kind, rsp.status, rsp.read_data, rsp.slow_clock,
                       rsp.chip_select_level, rsp.send_byte};
   assign rsp_tuser = {rsp.need_write_data, rsp.read_valid, rsp.exchange_request};
   assign rsp_tlast = rsp.done_res;

   `ASSERT_IMPLIES(a_done_no_xch, clock, reset, rsp_tvalid && rsp_tlast, !rsp_tuser[0] && !rsp_tuser[2])
   `ASSERT_IMPLIES(a_read_with_xch, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   `ASSERT_IMPLIES(a_need_selected, clock, reset, rsp_tvalid && rsp_tuser[2], !rsp_tuser[0] && !rsp_tdata[8])
   `ASSERT_IMPLIES(a_stall_full, clock, reset, !req_tready, head_valid)

endmodule

// File: dv/tb_sd_spi_card_host_sequencer.sv
module tb_sd_spi_card_host_sequencer;
   import sdh_pkg::*;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] sector;
      logic [7:0]  count;
      logic [7:0]  card_byte;
      logic [7:0]  wdata;
   } req_item_t;

   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sd_spi_card_host_sequencer uut (.*);

   always #5 clock = ~clock;

   // sequencer predictor state
   int          ready_lim, token_lim, loop_lim, retry_lim, resp_lim;
   logic [4:0]  ph, sg;
   logic [2:0]  ctype, blk_st, kept_st, fin_st;
   logic [47:0] frame;
   int          fidx, bcnt, polls, loops, raw_n;
   logic [31:0] addr;
   logic [7:0]  left, resp8, cmd_no, tok;
   logic        slow, cs, flag, nrdy, in_init;
   rsp_type     nxt;
   logic        got;

   req_item_t   pending[$];
   rsp_type     expected_rsp[$];
   rsp_type     latest;
   int          items_in, errors, idle_cycles, flaky;
   int          n_init, n_read, n_write, n_rx_bytes, n_tx_bytes, n_fail_done;
   logic        took;
   int          burst_left, gap_left, stall_mode, stall_timer;

   function automatic void emit(input logic [7:0] b, input logic x);
      nxt = '0;
      nxt.send_byte = b;
      nxt.exchange_request = x;
      nxt.chip_select_level = cs;
      nxt.slow_clock = slow;
      nxt.card_kind = ctype;
      got = 1'b1;
   endfunction

   function automatic void send_cmd(input logic [7:0] idx, input logic [31:0] arg,
                                    input logic [7:0] crc);
      frame = {8'h40 | idx, arg, crc};
      cmd_no = idx;
      cs = 1'b0;
      polls = 0;
      sg = S_RDY;
      emit(8'hFF, 1'b1);
   endfunction

   function automatic void raw_bytes(input int n);
      raw_n = n; bcnt = 0; sg = S_RAW; flag = 1'b0;
      emit(8'hFF, 1'b1);
   endfunction

   function automatic void get_block();
      polls = 0; sg = S_TOKEN; emit(8'hFF, 1'b1);
   endfunction

   function automatic void put_block(input logic [7:0] t);
      tok = t; polls = 0; sg = S_BRDY; emit(8'hFF, 1'b1);
   endfunction

   function automatic void wrap_up(input logic [2:0] st);
      fin_st = st; cs = 1'b1; sg = S_END; ph = P_FIN;
      emit(8'hFF, 1'b1);
   endfunction

   function automatic void init_done();
      wrap_up((ctype >= K_MMC && ctype <= K_V2HC) ? ST_OK : ST_INITFAIL);
   endfunction

   function automatic logic [2:0] cmd_fail();
      return nrdy ? ST_NOTREADY : ST_NORESP;
   endfunction

   function automatic void next_phase();
      logic [7:0] r;
      r = resp8;
      case (ph)
         I_CLK: begin ph = I_CMD0; loops = retry_lim; send_cmd(0, 0, 8'h95); end
         I_CMD0: begin
            if (r == 8'h01) begin ph = I_CMD8; send_cmd(8, 32'h1AA, 8'h87); end
            else if (loops == 0) init_done();
            else begin loops--; send_cmd(0, 0, 8'h95); end
         end
         I_CMD8: begin
            if (r == 8'h01) begin ph = I_R7; raw_bytes(4); end
            else begin ph = I_A55; send_cmd(55, 0, 8'h01); end
         end
         I_R7: begin
            if (flag) begin ph = I_V2_55; loops = loop_lim; send_cmd(55, 0, 8'h01); end
            else init_done();
         end
         I_V2_55: begin ph = I_V2_41; send_cmd(41, 32'h40000000, 8'h01); end
         I_V2_41: begin
            if (r == 0) begin ph = I_CMD58; send_cmd(58, 0, 8'h01); end
            else if (loops == 0) init_done();
            else begin loops--; ph = I_V2_55; send_cmd(55, 0, 8'h01); end
         end
         I_CMD58: begin
            if (r == 0) begin ph = I_OCR; raw_bytes(4); end
            else init_done();
         end
         I_OCR: begin ctype = flag ? K_V2HC : K_V2; init_done(); end
         I_A55: begin ph = I_A41; send_cmd(41, 0, 8'h01); end
         I_A41: begin
            loops = loop_lim;
            if (r <= 1) begin ctype = K_V1; ph = I_V1_55; send_cmd(55, 0, 8'h01); end
            else begin ctype = K_MMC; ph = I_MMC1; send_cmd(1, 0, 8'h01); end
         end
         I_V1_55: begin ph = I_V1_41; send_cmd(41, 0, 8'h01); end
         I_V1_41, I_MMC1: begin
            if (r == 0) begin ph = I_CMD16; send_cmd(16, BLOCK_BYTES, 8'h01); end
            else if (loops == 0) begin ctype = K_ERROR; init_done(); end
            else if (ph == I_MMC1) begin loops--; send_cmd(1, 0, 8'h01); end
            else begin loops--; ph = I_V1_55; send_cmd(55, 0, 8'h01); end
         end
         I_CMD16: begin
            if (r != 0) ctype = K_ERROR;
            init_done();
         end
         R_SINGLE: begin
            if (r != 0) wrap_up(cmd_fail());
            else begin ph = R_SBLK; get_block(); end
         end
         R_SBLK: wrap_up(blk_st);
         R_MCMD: begin ph = R_MBLK; get_block(); end
         R_MBLK: begin
            left--;
            if (left != 0 && blk_st == ST_OK) get_block();
            else begin kept_st = blk_st; ph = R_STOP; send_cmd(12, 0, 8'h01); end
         end
         R_STOP: wrap_up(kept_st);
         W_SCMD: begin
            if (r != 0) wrap_up(cmd_fail());
            else begin ph = W_SBLK; put_block(8'hFE); end
         end
         W_SBLK: wrap_up(blk_st);
         W_55: begin ph = W_23; send_cmd(23, {24'd0, left}, 8'h01); end
         W_23: begin ph = W_MCMD; send_cmd(25, addr, 8'h01); end
         W_MCMD: begin
            if (r != 0) wrap_up(cmd_fail());
            else begin ph = W_MBLK; put_block(8'hFC); end
         end
         W_MBLK: begin
            left--;
            if (left != 0 && blk_st == ST_OK) put_block(8'hFC);
            else begin kept_st = blk_st; ph = W_STOP; put_block(8'hFD); end
         end
         W_STOP: wrap_up(kept_st != ST_OK ? kept_st : blk_st);
         default: begin sg = S_NONE; ph = P_IDLE; end
      endcase
   endfunction

   function automatic void card_answer(input logic [7:0] b);
      case (sg)
         S_RDY: begin
            if (b == 8'hFF) begin
               fidx = 0; sg = S_FRAME; emit(frame[47:40], 1'b1);
            end else begin
               polls++;
               if (polls >= ready_lim) begin cs = 1'b1; sg = S_DESEL; end
               emit(8'hFF, 1'b1);
            end
         end
         S_DESEL: begin nrdy = 1'b1; resp8 = 8'hFF; sg = S_NONE; next_phase(); end
         S_FRAME: begin
            fidx++;
            if (fidx < 6) emit(8'(frame >> (40 - 8 * fidx)), 1'b1);
            else if (cmd_no == 12) begin sg = S_STUFF; emit(8'hFF, 1'b1); end
            else begin sg = S_RESP; polls = 0; emit(8'hFF, 1'b1); end
         end
         S_STUFF: begin sg = S_RESP; polls = 0; emit(8'hFF, 1'b1); end
         S_RESP: begin
            if (b[7] && polls < resp_lim) begin polls++; emit(8'hFF, 1'b1); end
            else begin resp8 = b; nrdy = 1'b0; sg = S_NONE; next_phase(); end
         end
         S_RAW: begin
            if (ph == I_R7) begin
               if (bcnt == 2) flag = (b == 8'h01);
               if (bcnt == 3) flag = flag && (b == 8'hAA);
            end else if (bcnt == 0) flag = b[6];
            bcnt++;
            if (bcnt >= raw_n) begin sg = S_NONE; next_phase(); end
            else emit(8'hFF, 1'b1);
         end
         S_TOKEN: begin
            if (b == 8'hFE) begin bcnt = 0; sg = S_DIN; emit(8'hFF, 1'b1); end
            else begin
               polls++;
               if (polls >= token_lim) begin blk_st = ST_NORESP; sg = S_NONE; next_phase(); end
               else emit(8'hFF, 1'b1);
            end
         end
         S_DIN: begin
            bcnt++;
            if (bcnt >= BLOCK_BYTES) begin sg = S_CRCIN; bcnt = 0; end
            emit(8'hFF, 1'b1);
            nxt.read_data = b;
            nxt.read_valid = 1'b1;
         end
         S_CRCIN: begin
            bcnt++;
            if (bcnt < 2) emit(8'hFF, 1'b1);
            else begin blk_st = ST_OK; sg = S_NONE; next_phase(); end
         end
         S_BRDY: begin
            if (b == 8'hFF) begin sg = S_TOK; emit(tok, 1'b1); end
            else begin
               polls++;
               if (polls >= ready_lim) begin blk_st = ST_NOTREADY; sg = S_NONE; next_phase(); end
               else emit(8'hFF, 1'b1);
            end
         end
         S_TOK: begin
            if (tok == 8'hFD) begin blk_st = ST_OK; sg = S_NONE; next_phase(); end
            else begin bcnt = 0; sg = S_NEED; emit(0, 1'b0); nxt.need_write_data = 1'b1; end
         end
         S_DOUT: begin
            bcnt++;
            if (bcnt < BLOCK_BYTES) begin
               sg = S_NEED; emit(0, 1'b0); nxt.need_write_data = 1'b1;
            end else begin sg = S_CRCOUT; bcnt = 0; emit(8'hFF, 1'b1); end
         end
         S_CRCOUT: begin
            bcnt++;
            if (bcnt >= 2) sg = S_DRESP;
            emit(8'hFF, 1'b1);
         end
         S_DRESP: begin
            blk_st = (b[4:0] == 5'h05) ? ST_OK : ST_REJECT;
            sg = S_NONE;
            next_phase();
         end
         S_END: begin
            if (in_init) slow = 1'b0;
            in_init = 1'b0; sg = S_NONE; ph = P_IDLE;
            emit(0, 1'b0);
            nxt.done_res = 1'b1;
            nxt.status = fin_st;
         end
         default: ;
      endcase
   endfunction

   function automatic void start_transfer(input logic wr, input logic [31:0] sector,
                                          input logic [7:0] cnt);
      if (cnt == 0) begin
         emit(0, 1'b0);
         nxt.done_res = 1'b1;
         return;
      end
      addr = (ctype == K_V2HC) ? sector : (sector << 9);
      left = cnt;
      if (!wr) begin
         if (cnt == 1) begin ph = R_SINGLE; send_cmd(17, addr, 8'h01); end
         else begin ph = R_MCMD; send_cmd(18, addr, 8'h01); end
      end else if (cnt == 1) begin ph = W_SCMD; send_cmd(24, addr, 8'h01); end
      else if (ctype != K_MMC) begin ph = W_55; send_cmd(55, 0, 8'h01); end
      else begin ph = W_MCMD; send_cmd(25, addr, 8'h01); end
   endfunction

   function automatic void predict_item(input req_item_t it);
      got = 1'b0;
      if (it.action == A_INIT && ph == P_IDLE) begin
         ph = I_CLK; slow = 1'b1; cs = 1'b1; ctype = K_NONE; in_init = 1'b1;
         raw_bytes(10);
      end else if ((it.action == A_READ || it.action == A_WRITE) && ph == P_IDLE) begin
         start_transfer(it.action == A_WRITE, it.sector, it.count);
      end else if (it.action == A_BYTE && sg != S_NONE && sg != S_NEED) begin
         card_answer(it.card_byte);
      end else if (it.action == A_WDATA && sg == S_NEED) begin
         sg = S_DOUT;
         emit(it.wdata, 1'b1);
         n_tx_bytes++;
      end
      if (got) begin
         expected_rsp.push_back(nxt);
         latest = nxt;
      end
   endfunction

   function automatic void predictor_reset();
      ready_lim = 24'hFFFFFF; token_lim = 65535; loop_lim = 65534;
      retry_lim = 20; resp_lim = 31;
      ph = P_IDLE; sg = S_NONE; ctype = K_NONE; frame = '0; fidx = 0; bcnt = 0;
      polls = 0; loops = 0; addr = '0; left = '0; resp8 = '0; slow = 1'b1;
      cmd_no = '0; raw_n = 0; tok = '0; blk_st = '0; kept_st = '0; fin_st = '0;
      cs = 1'b1; flag = 1'b0; nrdy = 1'b0; in_init = 1'b0;
   endfunction

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // emulated card, steered by what the sequencer currently waits for
   function automatic logic [7:0] card_reply();
      logic [7:0] good;
      case (sg)
         S_RDY, S_BRDY: return chance(flaky) ? 8'($urandom_range(0, 254)) : 8'hFF;
         S_RESP: begin
            if (chance(25)) return 8'h80 | 8'($urandom);
            if (chance(flaky)) return 8'($urandom_range(0, 127));
            case (ph)
               I_CMD0, I_V2_55, I_A55, I_V1_55: good = 8'h01;
               I_CMD8: good = chance(50) ? 8'h01 : 8'h05;
               I_A41: good = chance(50) ? 8'h01 : 8'h05;
               I_V2_41, I_V1_41, I_MMC1: good = chance(40) ? 8'h01 : 8'h00;
               default: good = 8'h00;
            endcase
            return good;
         end
         S_RAW: begin
            if (ph == I_R7 && !chance(flaky)) begin
               if (bcnt == 2) return 8'h01;
               if (bcnt == 3) return 8'hAA;
            end
            return 8'($urandom);
         end
         S_TOKEN: begin
            if (chance(30)) return 8'hFF;
            return chance(flaky) ? 8'($urandom) : 8'hFE;
         end
         S_DRESP: return chance(flaky) ? 8'($urandom) : {3'($urandom), 5'h05};
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic issue(input logic [2:0] a, input logic [7:0] cb);
      req_item_t it;
      it.action = a;
      it.sector = $urandom;
      it.count = 8'($urandom);
      it.card_byte = cb;
      it.wdata = 8'($urandom);
      pending.push_back(it);
      do @(negedge clock); while (pending.size() != 0 || expected_rsp.size() != 0);
   endtask

   task automatic noise();
      logic [2:0] a;
      if (sg == S_NEED) a = 3'($urandom_range(0, 3));
      else begin
         a = 3'($urandom_range(0, 3));
         if (a == A_BYTE) a = A_WDATA;
      end
      if (chance(40)) a = 3'($urandom_range(5, 7));
      if (ph == P_IDLE && a <= A_WRITE) a = A_BYTE;
      issue(a, 8'($urandom));
   endtask

   task automatic run_request(input logic [2:0] a, input logic [31:0] sector,
                              input logic [7:0] cnt);
      req_item_t it;
      it.action = a; it.sector = sector; it.count = cnt;
      it.card_byte = 8'($urandom); it.wdata = 8'($urandom);
      pending.push_back(it);
      do @(negedge clock); while (pending.size() != 0 || expected_rsp.size() != 0);
      if (a == A_INIT) n_init++;
      else if (a == A_READ) n_read++;
      else n_write++;
      while (!latest.done_res) begin
         if (chance(3)) noise();
         if (latest.need_write_data) issue(A_WDATA, 8'($urandom));
         else issue(A_BYTE, card_reply());
      end
      if (latest.status != ST_OK) n_fail_done++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_READY_POLL: ready_lim = val[23:0];
         REG_TOKEN_POLL: token_lim = val[15:0];
         REG_INIT_LOOP:  loop_lim = val[15:0];
         REG_RESET_TRY:  retry_lim = val[7:0];
         default:        resp_lim = val[7:0];
      endcase
   endtask

   task automatic set_limits(input int rdy, input int tkn, input int lp, input int rt,
                             input int rp);
      repeat (6) @(negedge clock);
      csr_write(REG_READY_POLL, rdy);
      csr_write(REG_TOKEN_POLL, tkn);
      csr_write(REG_INIT_LOOP, lp);
      csr_write(REG_RESET_TRY, rt);
      csr_write(REG_RESP_POLL, rp);
   endtask

   // a sector moves over 500 items, so without wide counts transfers only start when the budget has room
   task automatic random_phase(input int n_items, input bit wide_counts);
      int stop_at, room;
      logic [7:0] cnt;
      stop_at = items_in + n_items;
      while (items_in < stop_at) begin
         room = stop_at - items_in;
         if (chance(10)) noise();
         if (wide_counts && chance(60)) cnt = 8'($urandom_range(1, 255));
         else if (room >= 800) cnt = 8'd2;
         else cnt = 8'd1;
         if (ctype == K_NONE || chance(20) || (!wide_counts && room < 560))
            run_request(A_INIT, 0, 0);
         else run_request(chance(50) ? A_READ : A_WRITE, $urandom, cnt);
      end
   endtask

   // request side: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !took) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tuser <= pending[0].action;
         req_tdata <= {pending[0].wdata, pending[0].card_byte, pending[0].count,
                       pending[0].sector};
         if (burst_left <= 0) burst_left = $urandom_range(1, 16);
         burst_left--;
         if (burst_left == 0 && chance(70)) gap_left = $urandom_range(1, 6);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result side stall pattern
   always @(negedge clock) begin
      if (stall_timer <= 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_timer = $urandom_range(20, 120);
      end
      stall_timer--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= chance(60);
         default: rsp_tready <= (stall_timer % 4) != 0;
      endcase
   end

   always @(posedge clock) begin
      rsp_type act, exp;
      took = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            predict_item(pending.pop_front());
            items_in++;
            took = 1'b1;
            idle_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            act = '0;
            act.send_byte = rsp_tdata[7:0];
            act.chip_select_level = rsp_tdata[8];
            act.slow_clock = rsp_tdata[9];
            act.read_data = rsp_tdata[17:10];
            act.status = rsp_tdata[20:18];
            act.card_kind = rsp_tdata[23:21];
            act.exchange_request = rsp_tuser[0];
            act.read_valid = rsp_tuser[1];
            act.need_write_data = rsp_tuser[2];
            act.done_res = rsp_tlast;
            if (act.read_valid) n_rx_bytes++;
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result item %p", act);
            end else begin
               exp = expected_rsp.pop_front();
               if (act !== exp) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %p actual %p", exp, act);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int wait_cycles;
      predictor_reset();
      flaky = 8;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle noise with extreme fields, empty transfers, then a clean init
      pending.push_back('{A_BYTE, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF});
      pending.push_back('{A_WDATA, 32'h0, 8'h0, 8'h0, 8'h0});
      pending.push_back('{3'd5, 32'h0, 8'hFF, 8'h0, 8'hFF});
      pending.push_back('{3'd6, 32'hFFFFFFFF, 8'h0, 8'hFF, 8'h0});
      pending.push_back('{3'd7, 32'hA5A5A5A5, 8'h5A, 8'h5A, 8'hA5});
      run_request(A_READ, 32'hFFFFFFFF, 8'd0);
      run_request(A_WRITE, 32'h0, 8'd0);
      flaky = 0;
      run_request(A_INIT, 0, 0);
      flaky = 8;

      random_phase(850, 1'b0);
      flaky = 60;
      set_limits(1, 1, 1, 1, 1);
      random_phase(100, 1'b1);
      flaky = 8;
      set_limits(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      random_phase(100, 1'b0);
      set_limits($urandom_range(2, 40), $urandom_range(2, 40), $urandom_range(1, 10),
                 $urandom_range(1, 10), $urandom_range(2, 20));
      random_phase(150, 1'b0);

      wait_cycles = 0;
      while ((pending.size() != 0 || expected_rsp.size() != 0) && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      if (expected_rsp.size() != 0) begin
         errors++;
         $display("%0d expected result items never arrived", expected_rsp.size());
      end
      repeat (10) @(negedge clock);
      $display("items %0d: %0d inits, %0d reads, %0d writes, %0d failed requests",
               items_in, n_init, n_read, n_write, n_fail_done);
      $display("sector bytes received %0d, sent %0d", n_rx_bytes, n_tx_bytes);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
